FILE: src/ckc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types and constants for the chained key cipher with CRC-32.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 6;
  localparam int WORD_BYTES = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd2;

  localparam logic [31:0] CRC_REFL_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

  localparam logic MODE_DECRYPT = 1'b0;
  localparam logic MODE_ENCRYPT = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } ckc_entry_t;

  typedef struct packed {
    logic       valid;
    ckc_entry_t entry;
  } ckc_head_t;

endpackage

FILE: src/ckc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_front
// Accepts input transactions, tracks the key position and attaches the key
// byte to each byte before it enters the queue.
// ----------------------------------------------------------------------------
module ckc_front #(
  parameter int KEY_BYTES = 32,
  parameter int POS_W     = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last_byte,
  input  logic [ckc_pkg::LEN_W-1:0]         key_len,
  input  logic [KEY_BYTES-1:0][7:0]         key_bytes,
  input  logic                              q_full,
  output logic                              q_push,
  output ckc_pkg::ckc_entry_t               q_entry
);

  localparam logic [ckc_pkg::LEN_W-1:0] MAX_LEN = ckc_pkg::LEN_W'(KEY_BYTES);

  logic [POS_W-1:0]          key_pos_r, key_pos_nxt;
  logic [POS_W-1:0]          pos;
  logic [ckc_pkg::LEN_W-1:0] eff_len;
  logic [ckc_pkg::LEN_W-1:0] pos_inc;

  always_comb begin
    if (key_len == '0) begin
      eff_len = ckc_pkg::LEN_W'(1);
    end else if (key_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_len;
    end
    pos = (ckc_pkg::LEN_W'(key_pos_r) >= eff_len) ? '0 : key_pos_r;
    pos_inc = ckc_pkg::LEN_W'(pos) + ckc_pkg::LEN_W'(1);
    if (in_last_byte || pos_inc >= eff_len) begin
      key_pos_nxt = '0;
    end else begin
      key_pos_nxt = pos_inc[POS_W-1:0];
    end
  end

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_entry.data  = in_byte;
  assign q_entry.key   = key_bytes[pos];
  assign q_entry.last  = in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
    end else if (q_push) begin
      key_pos_r <= key_pos_nxt;
    end
  end

endmodule

FILE: src/ckc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ckc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ckc_pkg::ckc_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output ckc_pkg::ckc_head_t  head
);

  ckc_pkg::ckc_entry_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

FILE: src/ckc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_back
// Chained add or subtract, CRC-32 over the plaintext, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module ckc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  ckc_pkg::ckc_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [31:0]        out_plain_crc,
  output logic               out_end_mark
);

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ ckc_pkg::CRC_REFL_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0]  prev_cipher_r, prev_cipher_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  res, plain;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_crc_r;
  logic        out_end_r;

  assign pop = head.valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (mode == ckc_pkg::MODE_ENCRYPT) begin
      res             = head.entry.data + head.entry.key + prev_cipher_r;
      plain           = head.entry.data;
      prev_cipher_nxt = res;
    end else begin
      res             = head.entry.data - head.entry.key - prev_cipher_r;
      plain           = res;
      prev_cipher_nxt = head.entry.data;
    end
    crc_nxt = crc_step(crc_r, plain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cipher_r <= '0;
      crc_r         <= ckc_pkg::CRC_INIT;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        if (head.entry.last) begin
          prev_cipher_r <= '0;
          crc_r         <= ckc_pkg::CRC_INIT;
        end else begin
          prev_cipher_r <= prev_cipher_nxt;
          crc_r         <= crc_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= res;
      out_crc_r  <= head.entry.last ? ~crc_nxt : 32'd0;
      out_end_r  <= head.entry.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_plain_crc = out_crc_r;
  assign out_end_mark  = out_end_r;

endmodule

FILE: src/chained_key_cipher_with_crc32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_key_cipher_with_crc32_core
// Chained additive byte cipher with CRC-32 of the plaintext.
// ----------------------------------------------------------------------------
// Takes one byte per clock while in_stall is low and returns one result per
// byte, in order. A byte passes the front (key selection) into a two-entry
// queue and is then processed by the back stage, whose chained add and
// unrolled CRC-32 update are combinational ahead of the result register.
// Input stall rises only when the queue fills because the result channel
// is stalled. Registers are written through cfg_we/cfg_index/cfg_wdata
// and must only change while no transaction is in flight. The plaintext
// CRC is reported with the byte flagged last; that byte also clears the
// chaining state, key position and CRC for the next buffer.
module chained_key_cipher_with_crc32_core #(
  parameter int KEY_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ckc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ckc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic [31:0]                        out_plain_crc,
  output logic                               out_end_mark
);

  localparam int POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic                          mode_r;
  logic [ckc_pkg::LEN_W-1:0]     key_len_r;
  logic [KEY_BYTES-1:0][7:0]     key_r;

  logic                          q_push;
  logic                          q_full;
  logic                          q_pop;
  ckc_pkg::ckc_entry_t           q_entry;
  ckc_pkg::ckc_head_t            q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ckc_pkg::MODE_DECRYPT;
      key_len_r <= ckc_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == ckc_pkg::CFG_MODE) begin
        mode_r <= cfg_wdata[0];
      end
      if (cfg_index == ckc_pkg::CFG_KEY_LENGTH) begin
        key_len_r <= cfg_wdata[ckc_pkg::LEN_W-1:0];
      end
    end
  end

  for (genvar g = 0; g < KEY_BYTES; g++) begin : g_key
    localparam logic [ckc_pkg::CFG_IDX_W-1:0] WORD_IDX =
      ckc_pkg::CFG_IDX_W'(int'(ckc_pkg::CFG_KEY_WORD_0) + g / ckc_pkg::WORD_BYTES);
    localparam int LANE = g % ckc_pkg::WORD_BYTES;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[g] <= '0;
      end else if (cfg_we && cfg_index == WORD_IDX) begin
        key_r[g] <= cfg_wdata[LANE*8 +: 8];
      end
    end
  end

  ckc_front #(
    .KEY_BYTES (KEY_BYTES),
    .POS_W     (POS_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .key_len      (key_len_r),
    .key_bytes    (key_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  ckc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  ckc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_plain_crc (out_plain_crc),
    .out_end_mark  (out_end_mark)
  );

endmodule

FILE: src/ckc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_checker
// Port-level checks for the chained key cipher core.
// ----------------------------------------------------------------------------
module ckc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [ckc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_byte,
  input logic                           in_last_byte,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [7:0]                     out_byte,
  input logic [31:0]                    out_plain_crc,
  input logic                           out_end_mark
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_plain_crc) && $stable(out_end_mark))
    else $error("result changed while stalled");

  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_mark |-> out_plain_crc == 32'd0)
    else $error("crc nonzero on a non-final transaction");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind chained_key_cipher_with_crc32_core ckc_checker u_ckc_checker (.*);

FILE: sim/ckc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_stream_checker
// Watches the register port and both channels of the chained key cipher core,
// keeps its own copy of the registers, the chaining state and the running
// CRC-32, predicts every result at input acceptance and compares each output
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ckc_stream_checker
  import ckc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_byte,
  input  logic [31:0]           out_plain_crc,
  input  logic                  out_end_mark,
  output int                    fail_count,
  output int                    pending
);

  localparam int KEY_SPAN  = 32;
  localparam int KEY_WORDS = 4;

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] crc;
    logic        end_mark;
  } cipher_result_t;

  cipher_result_t expected_q[$];

  logic                  mode_r;
  logic [LEN_W-1:0]      key_len_r;
  logic [8*KEY_SPAN-1:0] key_bits;
  logic [7:0]            chain_prev;
  logic [5:0]            key_idx;
  logic [31:0]           crc_run;

  cipher_result_t want;
  logic [5:0]     span;
  logic [5:0]     pos;
  logic [7:0]     kb;
  logic [7:0]     plain;
  logic [7:0]     cipher;
  int             word_sel;
  int             mismatches  = 0;
  int             outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_REFL_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_r     = MODE_DECRYPT;
      key_len_r  = LEN_W'(1);
      key_bits   = '0;
      chain_prev = 8'd0;
      key_idx    = 6'd0;
      crc_run    = CRC_INIT;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:       mode_r = cfg_wdata[0];
          CFG_KEY_LENGTH: key_len_r = cfg_wdata[LEN_W-1:0];
          default: begin
            word_sel = int'(cfg_index) - int'(CFG_KEY_WORD_0);
            if (word_sel >= 0 && word_sel < KEY_WORDS)
              key_bits[word_sel*CFG_DATA_W +: CFG_DATA_W] = cfg_wdata;
          end
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected transaction: byte %02h crc %08h end %0b", $time,
                   out_byte, out_plain_crc, out_end_mark);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t out_byte mismatch: expected %02h actual %02h", $time,
                     want.data, out_byte);
            mismatches++;
          end
          if (out_plain_crc !== want.crc) begin
            $display("%0t out_plain_crc mismatch: expected %08h actual %08h", $time,
                     want.crc, out_plain_crc);
            mismatches++;
          end
          if (out_end_mark !== want.end_mark) begin
            $display("%0t out_end_mark mismatch: expected %0b actual %0b", $time,
                     want.end_mark, out_end_mark);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        span = (key_len_r == 0) ? 6'd1 : (key_len_r > KEY_SPAN) ? 6'(KEY_SPAN) : key_len_r;
        pos  = (key_idx >= span) ? 6'd0 : key_idx;
        kb   = key_bits[{pos[4:0], 3'b000} +: 8];
        if (mode_r == MODE_ENCRYPT) begin
          plain  = in_byte;
          cipher = in_byte + kb + chain_prev;
          want.data = cipher;
        end else begin
          cipher = in_byte;
          plain  = in_byte - kb - chain_prev;
          want.data = plain;
        end
        crc_run    = crc32_step(crc_run, plain);
        chain_prev = cipher;
        key_idx    = (pos + 6'd1 >= span) ? 6'd0 : pos + 6'd1;
        want.crc      = in_last_byte ? ~crc_run : 32'd0;
        want.end_mark = in_last_byte;
        expected_q.push_back(want);
        if (in_last_byte) begin
          chain_prev = 8'd0;
          key_idx    = 6'd0;
          crc_run    = CRC_INIT;
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: sim/chained_key_cipher_with_crc32_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_key_cipher_with_crc32_core_tb
// Stimulus and verdict for the chained key cipher core. A directed part covers
// byte extremes, both modes, key length zero and above 32, a length lowered
// mid-buffer, unused register indexes and single-byte buffers; random buffers
// under varying key settings follow, with idle and stall on both channels, a
// long output hold-off that backs up the input, and pauses that drain the core.
// ----------------------------------------------------------------------------
module chained_key_cipher_with_crc32_core_tb;
  import ckc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 360;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_KEY_WORD_0 + 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_KEY_WORD_0 + 3'd5;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic [7:0]            in_byte      = 8'd0;
  logic                  in_last_byte = 1'b0;
  logic                  out_stall    = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            out_byte;
  logic [31:0]           out_plain_crc;
  logic                  out_end_mark;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  chained_key_cipher_with_crc32_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_plain_crc(out_plain_crc),
    .out_end_mark (out_end_mark)
  );

  ckc_stream_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_plain_crc(out_plain_crc),
    .out_end_mark (out_end_mark),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result channel back-pressure; a new hold request forces a long stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_key(input logic m, input logic [LEN_W-1:0] len,
                          input logic [255:0] key);
    set_reg(CFG_MODE, CFG_DATA_W'(m));
    set_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
    for (int k = 0; k < 4; k++) begin
      set_reg(CFG_KEY_WORD_0 + CFG_IDX_W'(k), key[k*64 +: 64]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key_word();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return LEN_W'(0);
      1:       return LEN_W'(1);
      2:       return LEN_W'(32);
      3:       return LEN_W'($urandom_range(33, 63));
      default: return LEN_W'($urandom_range(1, 32));
    endcase
  endfunction

  task automatic run_phase(input int s_pct, input int r_pct, input bit with_hold);
    int          target;
    int          nbufs;
    int          blen;
    bit          broken;
    logic        l;
    logic [255:0] key;
    settle();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      settle();
      case ($urandom_range(0, 5))
        0: begin
          set_reg(CFG_KEY_LENGTH, CFG_DATA_W'(rand_len()));
          cfg_we <= 1'b0;
        end
        1: begin
          set_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1) ? MODE_ENCRYPT : MODE_DECRYPT));
          cfg_we <= 1'b0;
        end
        default: begin
          for (int k = 0; k < 4; k++) key[k*64 +: 64] = rand_key_word();
          load_key($urandom_range(0, 1) ? MODE_ENCRYPT : MODE_DECRYPT, rand_len(), key);
        end
      endcase
      if (with_hold) begin
        hold_seq++;
        with_hold = 0;
      end
      nbufs = $urandom_range(1, 6);
      for (int n = 0; n < nbufs; n++) begin
        blen   = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < blen; j++) begin
          l = (j == blen - 1) && !broken;
          if ($urandom_range(0, 39) == 0) l = 1'b1;
          push_byte(8'($urandom_range(0, 255)), l);
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: decrypt, length one, zero key
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    load_key(MODE_ENCRYPT, LEN_W'(32),
             {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210,
              64'h0123_4567_89AB_CDEF});
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);
    settle();

    // length zero acts as length one
    load_key(MODE_DECRYPT, LEN_W'(0),
             {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h8040_2010_0804_0201,
              64'hFFEE_DDCC_BBAA_9988});
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // length above 32 saturates, then shrinks mid-buffer
    load_key(MODE_ENCRYPT, LEN_W'(63),
             {64'h1F1E_1D1C_1B1A_1918, 64'h1716_1514_1312_1110,
              64'h0F0E_0D0C_0B0A_0908, 64'h0706_0504_0302_0100});
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    settle();
    set_reg(CFG_KEY_LENGTH, CFG_DATA_W'(2));
    cfg_we <= 1'b0;
    push_byte(8'hFE, 1'b0);
    push_byte(8'h10, 1'b1);
    settle();

    // writes to unused indexes change nothing
    set_reg(CFG_SPARE_A, '1);
    set_reg(CFG_SPARE_B, '1);
    cfg_we <= 1'b0;
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    settle();

    // mode flip mid-buffer keeps chaining state
    push_byte(8'h33, 1'b0);
    push_byte(8'hCC, 1'b0);
    settle();
    set_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
    cfg_we <= 1'b0;
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);
    push_byte(8'h80, 1'b1);

    run_phase(14, 77, 1'b1);
    run_phase(77, 14, 1'b0);
    run_phase(0, 0, 1'b1);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ckc_pkg.sv
src/ckc_front.sv
src/ckc_queue.sv
src/ckc_back.sv
src/chained_key_cipher_with_crc32_core.sv
src/ckc_checker.sv
sim/ckc_stream_checker.sv
sim/chained_key_cipher_with_crc32_core_tb.sv
